[rtl/ple_pkg.sv]
// shared types and constants for the positional list engine
package ple_pkg;

    localparam int ByteW = 8;
    localparam int PosW  = 5;
    localparam int CntOutW = 5;
    // wide enough to hold any cell index below 256
    localparam int IdxW  = 9;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [ByteW-1:0] ErrByte = 8'hFF;

    // broadcast to every cell of the row
    typedef struct packed {
        logic            ins;
        logic            del;
        logic [PosW-1:0] pos;
    } cell_ctl_t;

endpackage

[rtl/positional_list_engine.sv]
// positional list engine: ordered byte list held in a row of shifting cells
//
// Requests arrive on the in channel (opcode, position, byte_in) under
// in_valid/in_ready; one result per request leaves on the out channel
// (byte_out, status, count_out) under out_valid/out_ready.
// A request is decoded, checked against the entry count and applied to the
// cell row in the cycle it is accepted: every cell above the insert point
// takes its left neighbour, or every cell from the delete point takes its
// right neighbour, all in that same cycle. The result is registered, so it
// appears in the cycle after acceptance.
// Throughput is one request per cycle while out_ready is high, set by the
// single output register, which is refilled in the same cycle it is taken.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken; no request is lost.
// Reset empties the list (count to zero) and clears out_valid; cell
// contents are left as they are, since only cells below the count are read.
// Errors (empty, out of range, full) return byte_out 255 and leave the
// list unchanged. Opcode 3 returns status ok, byte_out 0, no change.
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [4:0] position,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic [1:0] status,
    output logic [4:0] count_out
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int W  = (CW > PosW) ? CW : PosW;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ByteW-1:0] byte_out_reg;
    logic [1:0]       status_reg;
    logic [CntOutW-1:0] count_out_reg;

    logic [ByteW-1:0] byte_res;
    logic [1:0]       status_res;
    logic [CW-1:0]    count_res;
    logic             ins_ok;
    logic             del_ok;
    logic             in_fire;

    logic [W-1:0]     pos_w;
    logic [W-1:0]     cnt_w;
    logic [AW-1:0]    rd_idx;
    logic [ByteW-1:0] rd_data;

    cell_ctl_t        ctl;
    logic [ByteW-1:0] cell_q [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign pos_w   = W'(position);
    assign cnt_w   = W'(count_reg);
    assign rd_idx  = AW'(position);
    assign rd_data = cell_q[rd_idx];

    // request decode and range checks
    always_comb
    begin
        byte_res   = '0;
        status_res = ST_OK;
        count_res  = count_reg;
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        case (opcode)
            OP_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    byte_res   = ErrByte;
                    status_res = ST_RANGE;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    byte_res   = ErrByte;
                    status_res = ST_FULL;
                end
                else
                begin
                    ins_ok    = 1'b1;
                    count_res = count_reg + CW'(1);
                end
            end
            OP_DELETE, OP_READ:
            begin
                if (count_reg == '0)
                begin
                    byte_res   = ErrByte;
                    status_res = ST_EMPTY;
                end
                else if (pos_w >= cnt_w)
                begin
                    byte_res   = ErrByte;
                    status_res = ST_RANGE;
                end
                else
                begin
                    byte_res = rd_data;
                    if (opcode == OP_DELETE)
                    begin
                        del_ok    = 1'b1;
                        count_res = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                byte_res   = '0;
                status_res = ST_OK;
            end
        endcase
    end

    assign ctl.ins = in_fire && ins_ok;
    assign ctl.del = in_fire && del_ok;
    assign ctl.pos = position;

    assign count_next     = in_fire ? count_res : count_reg;
    assign out_valid_next = in_fire ? 1'b1 : (out_valid_reg && !out_ready);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ByteW-1:0] left_q;
            logic [ByteW-1:0] right_q;
            if (gi == 0)
            begin : g_first
                assign left_q = byte_in;
            end
            else
            begin : g_mid_l
                assign left_q = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_q = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_q = cell_q[gi+1];
            end
            ple_cell #(
                .IDX(gi)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .byte_in (byte_in),
                .left_q  (left_q),
                .right_q (right_q),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a request is taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_out_reg  <= byte_res;
            status_reg    <= status_res;
            count_out_reg <= CntOutW'(count_res);
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;
    assign status    = status_reg;
    assign count_out = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && status_res != ST_OK) |=> $stable(count_reg))
        else $error("failed request changed the count");

    a_error_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> byte_out == ErrByte)
        else $error("error result without error byte");

endmodule

[rtl/ple_cell.sv]
// one list entry; on a shift takes byte_in or its left or right neighbour
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  ple_pkg::cell_ctl_t     ctl,
    input  logic [7:0]             byte_in,
    input  logic [7:0]             left_q,
    input  logic [7:0]             right_q,
    output logic [7:0]             q
);
    import ple_pkg::*;

    localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

    logic [ByteW-1:0] data_reg;
    logic [ByteW-1:0] data_next;
    logic [IdxW-1:0]  pos_x;

    assign pos_x = IdxW'(ctl.pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (MyIdx == pos_x)
            begin
                data_next = byte_in;
            end
            else if (MyIdx > pos_x)
            begin
                data_next = left_q;
            end
        end
        else if (ctl.del)
        begin
            if (MyIdx >= pos_x)
            begin
                data_next = right_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
